### sv/spba_pkg.sv
// shared types, constants and helpers of the segregated pool block allocator
`timescale 1ns / 1ps
`default_nettype none

package spba_pkg;

    // defaults of the top-level parameters
    localparam int DEF_MAX_BLOCKS = 16;
    localparam int DEF_NUM_POOLS  = 4;
    localparam int DEF_ADDR_BITS  = 16;

    // fixed geometry of the register file and the payload
    localparam int NREG_POOLS = 4;
    localparam int POOL_W     = 2;
    localparam int BYTES_W    = 13;
    localparam int COUNT_W    = 5;
    localparam int REQ_W      = 16;
    localparam int OUT_ADDR_W = 16;
    localparam int STATUS_W   = 3;
    localparam int CMD_W      = 2;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 13;

    typedef logic [BYTES_W-1:0]  t_bytes;
    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_bytes MAX_BYTES = 13'd4096;
    localparam t_count MAX_COUNT = 5'd16;

    localparam t_bytes RESET_BYTES [NREG_POOLS] = '{13'd16, 13'd32, 13'd64, 13'd128};
    localparam t_count RESET_COUNT [NREG_POOLS] = '{5'd2, 5'd2, 5'd3, 5'd3};

    // commands
    localparam t_cmd CMD_ALLOC = 2'd0;
    localparam t_cmd CMD_FREE  = 2'd1;
    localparam t_cmd CMD_QUERY = 2'd2;

    // result status codes
    localparam t_status STAT_OK          = 3'd0;
    localparam t_status STAT_NO_SPACE    = 3'd1;
    localparam t_status STAT_OUT_OF_HEAP = 3'd2;
    localparam t_status STAT_NOT_START   = 3'd3;
    localparam t_status STAT_ALREADY     = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BYTES0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_COUNT0 = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END         = 4'd8;

    // compare results of the shared step unit
    typedef struct packed {
        logic fits_limit;
        logic addr_below;
        logic addr_at;
    } t_step_flags;

    // list memory controls
    typedef struct packed {
        logic wr_next;
        logic wr_off;
        logic rd;
    } t_mem_ctrl;

    function automatic t_bytes sat_bytes(input t_bytes b);
        t_bytes r;
        r = b;
        if (b == '0) r = 13'd1;
        else if (b > MAX_BYTES) r = MAX_BYTES;
        return r;
    endfunction

    function automatic t_count sat_count(input t_count c);
        return (c > MAX_COUNT) ? MAX_COUNT : c;
    endfunction

endpackage

`default_nettype wire

### sv/segregated_pool_block_allocator.sv
// allocate: pools are scanned in pool order for one that covers the request and still has
// a free block, whose link and offset are then read; free and query walk the blocks from
// the heap start to the address, or answer at once past the heap end or for the unused command
// one request in flight; the next is taken once the result sits in the output register
// after reset and after each write to a pool register the lists are rebuilt block by block,
// during which no request is taken; reset is synchronous, active low
`timescale 1ns / 1ps
`default_nettype none

module segregated_pool_block_allocator import spba_pkg::*; #(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
    parameter int NUM_POOLS  = DEF_NUM_POOLS,
    parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,   // request_bytes [15:0], block_address [31:16]
    input  logic [CMD_W-1:0]      i_s_tuser,   // cmd [1:0]
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,   // granted_address [15:0], status [18:16],
                                               // block_is_free [19], zero [23:20]
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PTR_W = $clog2(MAX_BLOCKS+1);
    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int ACC_W = ADDR_BITS + 1;
    localparam int SUM_W = ((ADDR_BITS > REQ_W) ? ADDR_BITS : REQ_W) + 1;

    localparam logic [2:0] S_RB_START = 3'd0;
    localparam logic [2:0] S_RB_STEP  = 3'd1;
    localparam logic [2:0] S_IDLE     = 3'd2;
    localparam logic [2:0] S_AL_SCAN  = 3'd3;
    localparam logic [2:0] S_AL_POP   = 3'd4;
    localparam logic [2:0] S_LOC      = 3'd5;
    localparam logic [2:0] S_FOUND    = 3'd6;
    localparam logic [2:0] S_OUT      = 3'd7;

    logic [2:0]           r_state;

    t_bytes               r_cfg_bytes [NREG_POOLS];
    t_count               r_cfg_count [NREG_POOLS];

    t_bytes               r_lay_bytes [NREG_POOLS];
    t_count               r_lay_cnt   [NREG_POOLS];
    logic [ACC_W-1:0]     r_heap_end;

    logic [PTR_W-1:0]     r_head [NREG_POOLS];
    logic [NREG_POOLS-1:0] r_head_vld;
    logic [MAX_BLOCKS-1:0] r_next_vld;
    logic [MAX_BLOCKS-1:0] r_free;

    logic [POOL_W-1:0]    r_pool;
    t_count               r_n;
    logic [PTR_W-1:0]     r_g;
    logic [ACC_W-1:0]     r_acc;

    t_cmd                 r_cmd;
    logic [REQ_W-1:0]     r_req;
    logic [REQ_W-1:0]     r_addr;

    logic [OUT_ADDR_W-1:0] r_res_addr;
    t_status              r_res_status;
    logic                 r_res_free;

    logic                 r_out_vld;
    logic [OUT_ADDR_W-1:0] r_out_addr;
    t_status              r_out_status;
    logic                 r_out_free;

    t_bytes               cur_bytes;
    t_count               want;
    logic [SUM_W-1:0]     sum;
    t_step_flags          flags;
    logic                 rb_add;
    logic                 last_pool;
    logic                 al_hit;
    logic                 pool_done;
    logic [PTR_W-1:0]     g_prev;
    logic [IDX_W-1:0]     blk_idx;
    logic [IDX_W-1:0]     prev_idx;
    logic                 in_xfer;
    logic                 cfg_xfer;
    logic                 out_slot;
    logic                 in_beyond;
    logic [REQ_W-1:0]     in_req;
    logic [REQ_W-1:0]     in_addr;
    logic                 free_ok;

    t_mem_ctrl            mem_ctrl;
    logic [IDX_W-1:0]     mem_raddr;
    logic [PTR_W-1:0]     mem_wnext;
    logic [PTR_W-1:0]     mem_rnext;
    logic [ADDR_BITS-1:0] mem_roff;

    assign in_req   = i_s_tdata[REQ_W-1:0];
    assign in_addr  = i_s_tdata[2*REQ_W-1:REQ_W];

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_s_tready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;
    assign in_xfer     = i_s_tvalid && o_s_tready;
    assign out_slot    = !r_out_vld || i_m_tready;

    // layout walk uses the raw register with saturation, everything else the stored layout
    assign cur_bytes = (r_state == S_RB_STEP) ? sat_bytes(r_cfg_bytes[r_pool])
                                              : r_lay_bytes[r_pool];
    assign want      = (32'(r_pool) >= NUM_POOLS) ? '0 : sat_count(r_cfg_count[r_pool]);

    spba_step #(
        .ADDR_BITS (ADDR_BITS)
    ) u_step (
        .i_acc   (r_acc),
        .i_bytes (cur_bytes),
        .i_addr  (r_addr),
        .o_sum   (sum),
        .o_flags (flags)
    );

    assign rb_add    = (r_n < want) && (r_g < PTR_W'(MAX_BLOCKS)) && flags.fits_limit;
    assign last_pool = (r_pool == POOL_W'(NREG_POOLS - 1));
    assign al_hit    = (r_req <= REQ_W'(r_lay_bytes[r_pool])) && r_head_vld[r_pool]
                       && (r_head[r_pool] < PTR_W'(MAX_BLOCKS));
    assign pool_done = (r_n >= r_lay_cnt[r_pool]);
    assign g_prev    = r_g - PTR_W'(1);
    assign blk_idx   = r_g[IDX_W-1:0];
    assign prev_idx  = g_prev[IDX_W-1:0];
    assign in_beyond = (SUM_W'(in_addr) >= SUM_W'(r_heap_end));
    assign free_ok   = (r_state == S_FOUND) && (r_cmd == CMD_FREE) && !r_free[blk_idx];

    assign mem_ctrl.wr_off  = (r_state == S_RB_STEP) && rb_add;
    assign mem_ctrl.wr_next = ((r_state == S_RB_STEP) && rb_add) || free_ok;
    assign mem_ctrl.rd      = (r_state == S_AL_SCAN) && al_hit;
    assign mem_wnext        = (r_state == S_RB_STEP) ? (r_g + PTR_W'(1)) : r_head[r_pool];
    assign mem_raddr        = r_head[r_pool][IDX_W-1:0];

    spba_list_mem #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_list_mem (
        .i_clk   (i_clk),
        .i_ctrl  (mem_ctrl),
        .i_waddr (blk_idx),
        .i_wnext (mem_wnext),
        .i_woff  (r_acc[ADDR_BITS-1:0]),
        .i_raddr (mem_raddr),
        .o_rnext (mem_rnext),
        .o_roff  (mem_roff)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RB_START;
            r_cfg_bytes <= RESET_BYTES;
            r_cfg_count <= RESET_COUNT;
            r_head_vld  <= '0;
            r_next_vld  <= '0;
            r_free      <= '1;
            r_out_vld   <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_slot) begin
                r_out_vld    <= 1'b1;
                r_out_addr   <= r_res_addr;
                r_out_status <= r_res_status;
                r_out_free   <= r_res_free;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_RB_START: begin
                    r_free     <= '1;
                    r_next_vld <= '0;
                    r_acc      <= '0;
                    r_g        <= '0;
                    r_pool     <= '0;
                    r_n        <= '0;
                    r_state    <= S_RB_STEP;
                end
                S_RB_STEP: begin
                    r_lay_bytes[r_pool] <= cur_bytes;
                    if (r_n == '0) begin
                        r_head[r_pool]     <= r_g;
                        r_head_vld[r_pool] <= rb_add;
                    end
                    if (rb_add) begin
                        // link the previous block of this pool to the new one
                        if (r_n != '0) begin
                            r_next_vld[prev_idx] <= 1'b1;
                        end
                        r_next_vld[blk_idx] <= 1'b0;
                        r_acc <= sum[ACC_W-1:0];
                        r_g   <= r_g + PTR_W'(1);
                        r_n   <= r_n + COUNT_W'(1);
                    end else begin
                        r_lay_cnt[r_pool] <= r_n;
                        r_n <= '0;
                        if (last_pool) begin
                            r_heap_end <= r_acc;
                            r_state    <= S_IDLE;
                        end else begin
                            r_pool <= r_pool + POOL_W'(1);
                        end
                    end
                end
                S_IDLE: begin
                    if (cfg_xfer) begin
                        if (i_cfg_index < CFG_POOL_COUNT0) begin
                            r_cfg_bytes[i_cfg_index[POOL_W-1:0]] <= i_cfg_data[BYTES_W-1:0];
                            r_state <= S_RB_START;
                        end else if (i_cfg_index < CFG_END) begin
                            r_cfg_count[i_cfg_index[POOL_W-1:0]] <= i_cfg_data[COUNT_W-1:0];
                            r_state <= S_RB_START;
                        end
                    end else if (in_xfer) begin
                        r_cmd        <= i_s_tuser;
                        r_req        <= in_req;
                        r_addr       <= in_addr;
                        r_res_addr   <= '0;
                        r_res_status <= STAT_OK;
                        r_res_free   <= 1'b0;
                        r_acc        <= '0;
                        r_g          <= '0;
                        r_pool       <= '0;
                        r_n          <= '0;
                        unique case (i_s_tuser) inside
                            CMD_ALLOC: begin
                                r_state <= S_AL_SCAN;
                            end
                            CMD_FREE, CMD_QUERY: begin
                                if (in_beyond) begin
                                    r_res_status <= STAT_OUT_OF_HEAP;
                                    r_state      <= S_OUT;
                                end else begin
                                    r_state <= S_LOC;
                                end
                            end
                            default: begin
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_AL_SCAN: begin
                    if (al_hit) begin
                        r_g                 <= r_head[r_pool];
                        r_free[mem_raddr]   <= 1'b0;
                        r_state             <= S_AL_POP;
                    end else if (last_pool) begin
                        r_res_status <= STAT_NO_SPACE;
                        r_state      <= S_OUT;
                    end else begin
                        r_pool <= r_pool + POOL_W'(1);
                    end
                end
                S_AL_POP: begin
                    r_head[r_pool]     <= mem_rnext;
                    r_head_vld[r_pool] <= r_next_vld[blk_idx];
                    r_res_addr         <= OUT_ADDR_W'(mem_roff);
                    r_state            <= S_OUT;
                end
                S_LOC: begin
                    if (pool_done) begin
                        if (last_pool) begin
                            r_res_status <= STAT_OUT_OF_HEAP;
                            r_state      <= S_OUT;
                        end else begin
                            r_pool <= r_pool + POOL_W'(1);
                            r_n    <= '0;
                        end
                    end else if (flags.addr_below) begin
                        if (flags.addr_at) begin
                            r_state <= S_FOUND;
                        end else begin
                            r_res_status <= STAT_NOT_START;
                            r_state      <= S_OUT;
                        end
                    end else begin
                        r_acc <= sum[ACC_W-1:0];
                        r_g   <= r_g + PTR_W'(1);
                        r_n   <= r_n + COUNT_W'(1);
                    end
                end
                S_FOUND: begin
                    if (r_cmd == CMD_FREE) begin
                        if (r_free[blk_idx]) begin
                            r_res_status <= STAT_ALREADY;
                        end else begin
                            // push as new head of its pool
                            r_head[r_pool]      <= r_g;
                            r_head_vld[r_pool]  <= 1'b1;
                            r_next_vld[blk_idx] <= r_head_vld[r_pool];
                            r_free[blk_idx]     <= 1'b1;
                        end
                    end else begin
                        r_res_free <= r_free[blk_idx];
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_slot) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_RB_START;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(M_TDATA_W - OUT_ADDR_W - STATUS_W - 1){1'b0}},
                         r_out_free, r_out_status, r_out_addr};

endmodule

`default_nettype wire

### sv/spba_step.sv
// shared add and compare unit used by the layout walk and the address walk
`timescale 1ns / 1ps
`default_nettype none

module spba_step import spba_pkg::*; #(
    parameter int ADDR_BITS = DEF_ADDR_BITS
) (
    input  logic [ADDR_BITS:0]                                       i_acc,
    input  t_bytes                                                   i_bytes,
    input  logic [REQ_W-1:0]                                         i_addr,
    output logic [((ADDR_BITS > REQ_W) ? ADDR_BITS : REQ_W):0]       o_sum,
    output t_step_flags                                              o_flags
);

    localparam int SUM_W = ((ADDR_BITS > REQ_W) ? ADDR_BITS : REQ_W) + 1;
    localparam logic [SUM_W-1:0] LIMIT = SUM_W'(1) << ADDR_BITS;

    logic [SUM_W-1:0] acc_ext;
    logic [SUM_W-1:0] addr_ext;

    assign acc_ext  = SUM_W'(i_acc);
    assign addr_ext = SUM_W'(i_addr);
    assign o_sum    = acc_ext + SUM_W'(i_bytes);

    assign o_flags.fits_limit = (o_sum <= LIMIT);
    assign o_flags.addr_below = (addr_ext < o_sum);
    assign o_flags.addr_at    = (addr_ext == acc_ext);

endmodule

`default_nettype wire

### sv/spba_list_mem.sv
// free-list link memory and block offset memory, one write and one read port
`timescale 1ns / 1ps
`default_nettype none

module spba_list_mem import spba_pkg::*; #(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
    parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
    input  logic                                              i_clk,
    input  t_mem_ctrl                                         i_ctrl,
    input  logic [((MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1)-1:0] i_waddr,
    input  logic [$clog2(MAX_BLOCKS+1)-1:0]                   i_wnext,
    input  logic [ADDR_BITS-1:0]                              i_woff,
    input  logic [((MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1)-1:0] i_raddr,
    output logic [$clog2(MAX_BLOCKS+1)-1:0]                   o_rnext,
    output logic [ADDR_BITS-1:0]                              o_roff
);

    localparam int PTR_W = $clog2(MAX_BLOCKS+1);

    logic [PTR_W-1:0]     mem_next [MAX_BLOCKS];
    logic [ADDR_BITS-1:0] mem_off  [MAX_BLOCKS];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_next) begin
            mem_next[i_waddr] <= i_wnext;
        end
        if (i_ctrl.wr_off) begin
            mem_off[i_waddr] <= i_woff;
        end
        if (i_ctrl.rd) begin
            o_rnext <= mem_next[i_raddr];
            o_roff  <= mem_off[i_raddr];
        end
    end

endmodule

`default_nettype wire

### sv/spba_checker.sv
// port-level checks of the segregated pool block allocator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module spba_checker import spba_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_s_tvalid,
    input wire logic                  o_s_tready,
    input wire logic                  o_m_tvalid,
    input wire logic                  i_m_tready,
    input wire logic [M_TDATA_W-1:0]  o_m_tdata,
    input wire logic                  i_cfg_valid,
    input wire logic                  o_cfg_ready,
    input wire logic [CFG_IDX_W-1:0]  i_cfg_index
);

    logic [OUT_ADDR_W-1:0] out_addr;
    t_status               out_status;
    logic                  out_free;
    logic                  cfg_xfer;
    logic                  in_xfer;

    assign out_addr   = o_m_tdata[OUT_ADDR_W-1:0];
    assign out_status = o_m_tdata[OUT_ADDR_W+STATUS_W-1:OUT_ADDR_W];
    assign out_free   = o_m_tdata[OUT_ADDR_W+STATUS_W];
    assign cfg_xfer   = i_cfg_valid && o_cfg_ready && (i_cfg_index < CFG_END);
    assign in_xfer    = i_s_tvalid && o_s_tready;

    // a pending result is not withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped before transfer");

    // a failed request never reports an address
    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (out_status != STAT_OK) |-> (out_addr == '0) && !out_free)
        else $error("failed request carries address or free flag");

    // a free flag comes only from a successful query
    a_free_is_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && out_free |-> (out_status == STAT_OK) && (out_addr == '0))
        else $error("free flag with address or error status");

    // a write to a pool register starts a rebuild, so no request is taken next
    a_cfg_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_xfer |=> !o_s_tready && !o_cfg_ready)
        else $error("request taken during list rebuild");

    // the block holds one request at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_s_tready)
        else $error("second request taken while one is in flight");

endmodule

bind segregated_pool_block_allocator spba_checker u_spba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_index (i_cfg_index)
);

`default_nettype wire

### tb/segregated_pool_block_allocator_tb.sv
// self-checking testbench for the segregated pool block allocator
`timescale 1ns / 1ps

module segregated_pool_block_allocator_tb;
    import spba_pkg::*;

    localparam int NBLK      = DEF_MAX_BLOCKS;
    localparam int HEAP_SPAN = 1 << DEF_ADDR_BITS;
    localparam t_cmd CMD_UNUSED = 2'd3;

    typedef struct packed {
        t_cmd        cmd;
        logic [15:0] req_bytes;
        logic [15:0] addr;
    } t_alloc_req;

    typedef struct packed {
        logic [15:0] granted;
        t_status     status;
        logic        blk_free;
    } t_alloc_rsp;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata   = '0;
    logic [CMD_W-1:0]      i_s_tuser   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    segregated_pool_block_allocator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("timeout: requests or results stuck");
        $display("end of test: mismatches");
        $finish;
    end

    // shadow of the allocator: registers, derived layout and free lists
    t_bytes     reg_bytes  [NREG_POOLS];
    t_count     reg_count  [NREG_POOLS];
    int         pool_bytes [NREG_POOLS];
    int         pool_base  [NREG_POOLS];
    int         pool_first [NREG_POOLS];
    int         pool_cnt   [NREG_POOLS];
    int         heap_top;
    logic [4:0] head       [NREG_POOLS];
    logic       head_ok    [NREG_POOLS];
    logic [4:0] link       [NBLK];
    logic       link_ok    [NBLK];
    logic       is_free    [NBLK];

    t_alloc_req request_queue [$];
    t_alloc_rsp awaited_results [$];
    t_alloc_req on_bus;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_trigger  = 0;
    int hold_ack      = 0;
    int hold_left     = 0;
    int requests_sent = 0;
    int results_seen  = 0;
    int reg_writes    = 0;
    int fail_count    = 0;
    int status_seen [8];

    function automatic void rebuild_pools();
        int base_acc, total, n, want, sz;
        base_acc = 0;
        total    = 0;
        for (int k = 0; k < NBLK; k++) begin
            link[k]    = '0;
            link_ok[k] = 1'b0;
            is_free[k] = 1'b1;
        end
        for (int p = 0; p < NREG_POOLS; p++) begin
            sz = reg_bytes[p];
            if (sz == 0) sz = 1;
            if (sz > MAX_BYTES) sz = MAX_BYTES;
            want = (reg_count[p] > MAX_COUNT) ? MAX_COUNT : reg_count[p];
            if (p >= DEF_NUM_POOLS) want = 0;
            n = 0;
            while (n < want && total + n < NBLK
                   && base_acc + sz * (n + 1) <= HEAP_SPAN)
                n++;
            pool_bytes[p] = sz;
            pool_base[p]  = base_acc;
            pool_first[p] = total;
            pool_cnt[p]   = n;
            for (int k = 0; k < n; k++) begin
                link[total + k]    = 5'(total + k + 1);
                link_ok[total + k] = (k + 1 < n);
            end
            head[p]    = 5'(total);
            head_ok[p] = (n > 0);
            base_acc  += sz * n;
            total     += n;
        end
        heap_top = base_acc;
    endfunction

    // pool and block index of a block start, else out of heap or not a start
    function automatic t_status find_block(input int addr, output int pool, output int blk);
        int rel;
        pool = 0;
        blk  = 0;
        if (addr >= heap_top) return STAT_OUT_OF_HEAP;
        for (int p = 0; p < NREG_POOLS; p++) begin
            if (addr >= pool_base[p]
                && addr < pool_base[p] + pool_bytes[p] * pool_cnt[p]) begin
                rel = addr - pool_base[p];
                if (rel % pool_bytes[p] != 0 || pool_first[p] + rel / pool_bytes[p] >= NBLK)
                    return STAT_NOT_START;
                pool = p;
                blk  = pool_first[p] + rel / pool_bytes[p];
                return STAT_OK;
            end
        end
        return STAT_OUT_OF_HEAP;
    endfunction

    function automatic t_alloc_rsp allocator_step(input t_alloc_req rq);
        t_alloc_rsp rsp;
        int g, blk, pool;
        bit done;
        rsp  = '0;
        done = 1'b0;
        case (rq.cmd)
            CMD_ALLOC: begin
                rsp.status = STAT_NO_SPACE;
                // first covering pool that still has a block, lowest pool index first
                for (int p = 0; p < NREG_POOLS; p++) begin
                    if (!done && rq.req_bytes <= pool_bytes[p]
                        && head_ok[p] && head[p] < NBLK) begin
                        g          = head[p];
                        head_ok[p] = link_ok[g];
                        head[p]    = link[g];
                        is_free[g] = 1'b0;
                        rsp.granted = 16'(pool_base[p] + (g - pool_first[p]) * pool_bytes[p]);
                        rsp.status  = STAT_OK;
                        done = 1'b1;
                    end
                end
            end
            CMD_FREE: begin
                rsp.status = find_block(rq.addr, pool, blk);
                if (rsp.status == STAT_OK) begin
                    if (is_free[blk]) begin
                        rsp.status = STAT_ALREADY;
                    end else begin
                        link[blk]     = head[pool];
                        link_ok[blk]  = head_ok[pool];
                        head[pool]    = 5'(blk);
                        head_ok[pool] = 1'b1;
                        is_free[blk]  = 1'b1;
                    end
                end
            end
            CMD_QUERY: begin
                rsp.status = find_block(rq.addr, pool, blk);
                if (rsp.status == STAT_OK) rsp.blk_free = is_free[blk];
            end
            default: ;
        endcase
        return rsp;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        $display("%0t check failed on %s: expected %0h, got %0h", $time, what, want, got);
        fail_count++;
    endtask

    // a block start most of the time, else an address inside a block, past the heap or anything
    function automatic logic [15:0] pick_addr();
        int p, k, s;
        if (heap_top == 0) return 16'($urandom);
        do p = $urandom_range(NREG_POOLS - 1); while (pool_cnt[p] == 0);
        k = $urandom_range(pool_cnt[p] - 1);
        s = $urandom_range(99);
        if (s < 80 || (s < 88 && pool_bytes[p] == 1))
            return 16'(pool_base[p] + k * pool_bytes[p]);
        if (s < 88)
            return 16'(pool_base[p] + k * pool_bytes[p]
                       + $urandom_range(pool_bytes[p] - 1, 1));
        if (s < 94)
            return 16'(heap_top + $urandom_range(3));
        return 16'($urandom);
    endfunction

    task automatic push_req(input t_cmd cmd, input int req_bytes, input int addr);
        t_alloc_req rq;
        rq.cmd       = cmd;
        rq.req_bytes = 16'(req_bytes);
        rq.addr      = 16'(addr);
        request_queue.push_back(rq);
    endtask

    task automatic push_random(input int count);
        int s, p, b, req;
        for (int i = 0; i < count; i++) begin
            s = $urandom_range(99);
            if (s < 45) begin
                p = $urandom_range(NREG_POOLS - 1);
                b = pool_bytes[p];
                case ($urandom_range(3))
                    0: req = b;
                    1: req = b + 1;
                    2: req = $urandom_range(b);
                    default: req = $urandom;
                endcase
                push_req(CMD_ALLOC, req, $urandom);
            end else if (s < 80) begin
                push_req(CMD_FREE, $urandom, pick_addr());
            end else if (s < 95) begin
                push_req(CMD_QUERY, $urandom, pick_addr());
            end else begin
                push_req(CMD_UNUSED, $urandom, $urandom);
            end
        end
    endtask

    // sampled away from the driving edge so every handshake has settled
    task automatic wait_idle();
        while (request_queue.size() != 0 || i_s_tvalid || awaited_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        reg_writes++;
        if (idx < CFG_POOL_COUNT0) reg_bytes[idx - CFG_POOL_BYTES0] = val;
        else if (idx < CFG_END) reg_count[idx - CFG_POOL_COUNT0] = val[COUNT_W-1:0];
        if (idx < CFG_END) rebuild_pools();
    endtask

    task automatic load_layout(input int b0, b1, b2, b3, c0, c1, c2, c3);
        int bytes_v [NREG_POOLS];
        int count_v [NREG_POOLS];
        bytes_v = '{b0, b1, b2, b3};
        count_v = '{c0, c1, c2, c3};
        for (int p = 0; p < NREG_POOLS; p++)
            write_reg(CFG_IDX_W'(CFG_POOL_BYTES0 + p), CFG_DATA_W'(bytes_v[p]));
        // bits above the count field carry noise
        for (int p = 0; p < NREG_POOLS; p++)
            write_reg(CFG_IDX_W'(CFG_POOL_COUNT0 + p),
                      CFG_DATA_W'(count_v[p] | ($urandom_range(255) << COUNT_W)));
    endtask

    task automatic start_hold();
        @(posedge i_clk);
        hold_trigger <= hold_trigger + 1;
    endtask

    always @(posedge i_clk) begin : driver
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (i_s_tvalid) begin
                awaited_results.push_back(allocator_step(on_bus));
                requests_sent++;
            end
            if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                on_bus = request_queue.pop_front();
                i_s_tdata  <= {on_bus.addr, on_bus.req_bytes};
                i_s_tuser  <= on_bus.cmd;
                i_s_tvalid <= 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // long receiver stall so the block backs up into its input
    always @(posedge i_clk) begin : stall_timer
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_trigger != hold_ack) begin
            hold_left <= 250;
            hold_ack  <= hold_trigger;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_alloc_rsp want, got;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got.granted  = o_m_tdata[15:0];
                got.status   = o_m_tdata[18:16];
                got.blk_free = o_m_tdata[19];
                results_seen++;
                if (awaited_results.size() == 0) begin
                    flag_mismatch("unexpected result", '0, got);
                end else begin
                    want = awaited_results.pop_front();
                    if (got.granted !== want.granted)
                        flag_mismatch("granted_address", want.granted, got.granted);
                    if (got.status !== want.status)
                        flag_mismatch("status", want.status, got.status);
                    if (got.blk_free !== want.blk_free)
                        flag_mismatch("block_is_free", want.blk_free, got.blk_free);
                    status_seen[want.status]++;
                end
            end
            i_m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        for (int p = 0; p < NREG_POOLS; p++) begin
            reg_bytes[p] = RESET_BYTES[p];
            reg_count[p] = RESET_COUNT[p];
        end
        for (int s = 0; s < 8; s++) status_seen[s] = 0;
        rebuild_pools();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 34;
        recv_idle_pct = 84;

        // reset layout: fall-through, exhaustion, bad addresses, double free
        push_req(CMD_QUERY, 16'hFFFF, 0);
        push_req(CMD_ALLOC, 0, 16'hFFFF);
        push_req(CMD_ALLOC, pool_bytes[0], 0);
        push_req(CMD_ALLOC, pool_bytes[0], 0);
        push_req(CMD_ALLOC, pool_bytes[0] + 1, 0);
        push_req(CMD_ALLOC, pool_bytes[0] + 4, 0);
        for (int i = 0; i < 4; i++)
            push_req(CMD_ALLOC, pool_bytes[3], 0);
        push_req(CMD_ALLOC, pool_bytes[3] + 1, 0);
        push_req(CMD_ALLOC, 16'hFFFF, 16'hFFFF);
        push_req(CMD_FREE, 0, pool_bytes[0]);
        push_req(CMD_FREE, 0, pool_bytes[0]);
        push_req(CMD_FREE, 0, pool_bytes[0] + 1);
        push_req(CMD_QUERY, 0, pool_bytes[0]);
        push_req(CMD_QUERY, 0, 0);
        push_req(CMD_FREE, 0, heap_top);
        push_req(CMD_QUERY, 16'hFFFF, 16'hFFFF);
        push_req(CMD_QUERY, 0, pool_base[3] + 1);
        push_req(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
        push_req(CMD_FREE, 16'hFFFF, 0);
        wait_idle();

        start_hold();
        push_random(260);
        wait_idle();

        load_layout(1, 2, 3, 4, 4, 4, 4, 4);
        push_random(260);
        wait_idle();

        send_idle_pct = 84;
        recv_idle_pct = 34;

        // zero and oversized block sizes, count saturation, sixteen blocks in one pool
        load_layout(4096, 8191, 0, 100, 16, 31, 0, 5);
        push_random(260);
        wait_idle();

        load_layout(8, 8, 64, 3000, 0, 3, 5, 20);
        push_random(260);
        wait_idle();

        // unused register indexes leave the lists alone
        write_reg(CFG_END, CFG_DATA_W'($urandom));
        write_reg(CFG_IDX_W'(CFG_END + 7), CFG_DATA_W'($urandom));
        push_random(120);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;

        load_layout(0, 0, 0, 0, 0, 0, 0, 0);
        push_random(60);
        wait_idle();

        load_layout(48, 24, 200, 7000, 3, 6, 2, 5);
        start_hold();
        push_random(340);
        wait_idle();

        load_layout(16, 32, 64, 128, 2, 2, 3, 3);
        push_random(340);
        wait_idle();

        repeat (40) @(posedge i_clk);

        $display("ran %0d requests, %0d results checked, %0d register writes",
                 requests_sent, results_seen, reg_writes);
        $display("outcomes: ok %0d, no space %0d, out of heap %0d, not block start %0d, %s %0d",
                 status_seen[STAT_OK], status_seen[STAT_NO_SPACE], status_seen[STAT_OUT_OF_HEAP],
                 status_seen[STAT_NOT_START], "already free", status_seen[STAT_ALREADY]);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
